@@ rtl/core/esd_pkg.sv @@
package esd_pkg;

	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
	} out_t;

	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [CNT_W-1:0]            count;
		logic                        eos;
	} dec_t;

endpackage

@@ rtl/core/esd_decode.sv @@
module esd_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  esd_pkg::in_t  sym,
	input  logic          take,
	output esd_pkg::dec_t res
);

	localparam logic [7:0] CH_BS = 8'h5C;
	localparam logic [7:0] CH_N  = 8'h6E;
	localparam logic [7:0] CH_T  = 8'h74;
	localparam logic [7:0] CH_R  = 8'h72;
	localparam logic [7:0] CH_X  = 8'h78;
	localparam logic [7:0] CH_DQ = 8'h22;
	localparam logic [7:0] CH_SQ = 8'h27;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_ESC,
		MODE_HEX0,
		MODE_HEX1
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [7:0] held_q, held_d;

	function automatic logic is_hex(input logic [7:0] c);
		logic r;
		r = 1'b0;
		if (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) begin
			r = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] r;
		if (c <= 8'h39) begin
			r = c[3:0];
		end else begin
			r = c[3:0] + 4'd9;
		end
		return r;
	endfunction

	always_comb begin
		logic [7:0]            b;
		logic                  last;
		logic                  do_plain;
		logic [esd_pkg::CNT_W-1:0] n;
		b        = sym.in_byte;
		last     = sym.end_of_string;
		do_plain = 1'b0;
		n        = '0;
		res      = '0;
		mode_d   = MODE_TEXT;
		held_d   = held_q;
		case (mode_q)
			MODE_TEXT: begin
				do_plain = 1'b1;
			end
			MODE_ESC: begin
				case (b)
					CH_N: begin
						res.bytes[n] = CH_LF;
						n = n + 1'b1;
					end
					CH_T: begin
						res.bytes[n] = CH_HT;
						n = n + 1'b1;
					end
					CH_R: begin
						res.bytes[n] = CH_CR;
						n = n + 1'b1;
					end
					CH_BS, CH_DQ, CH_SQ: begin
						res.bytes[n] = b;
						n = n + 1'b1;
					end
					CH_X: begin
						if (last) begin
							res.bytes[n] = CH_X;
							n = n + 1'b1;
						end else begin
							mode_d = MODE_HEX0;
						end
					end
					default: begin
						res.bytes[n] = CH_BS;
						n = n + 1'b1;
						res.bytes[n] = b;
						n = n + 1'b1;
					end
				endcase
			end
			MODE_HEX0: begin
				if (is_hex(b) && !last) begin
					held_d = b;
					mode_d = MODE_HEX1;
				end else begin
					res.bytes[n] = CH_X;
					n = n + 1'b1;
					do_plain = 1'b1;
				end
			end
			MODE_HEX1: begin
				if (is_hex(b)) begin
					res.bytes[n] = {hex_val(held_q), hex_val(b)};
					n = n + 1'b1;
				end else begin
					res.bytes[n] = CH_X;
					n = n + 1'b1;
					res.bytes[n] = held_q;
					n = n + 1'b1;
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase
		if (do_plain) begin
			if (b == CH_BS && !last) begin
				mode_d = MODE_ESC;
			end else begin
				res.bytes[n] = b;
				n = n + 1'b1;
			end
		end
		if (mode_d != MODE_HEX1) begin
			held_d = '0;
		end
		if (last) begin
			mode_d = MODE_TEXT;
			held_d = '0;
		end
		res.count = n;
		res.eos   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
			held_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			held_q <= held_d;
		end
	end

endmodule

@@ rtl/core/esd_out_buf.sv @@
module esd_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  esd_pkg::dec_t res,
	input  logic          load,
	output logic          room,
	output logic          decoded_valid,
	input  logic          decoded_stall,
	output esd_pkg::out_t decoded
);

	logic [esd_pkg::MAX_RESULTS-1:0][7:0] slot_q;
	logic [esd_pkg::CNT_W-1:0]            cnt_q;
	logic                                 eos_q;
	logic                                 pop;

	assign decoded_valid = (cnt_q != '0);
	assign pop           = decoded_valid && !decoded_stall;
	assign room          = (cnt_q == '0) ||
		(cnt_q == esd_pkg::CNT_W'(1) && !decoded_stall);

	assign decoded.out_byte    = slot_q[0];
	assign decoded.run_last    = (cnt_q == esd_pkg::CNT_W'(1));
	assign decoded.string_done = (cnt_q == esd_pkg::CNT_W'(1)) && eos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= res.bytes;
			eos_q  <= res.eos;
		end else if (pop) begin
			for (int i = 0; i < esd_pkg::MAX_RESULTS - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
	end

endmodule

@@ rtl/core/escape_sequence_decoder.sv @@
// Decodes C string escapes from a byte stream and accepts one source byte per
// cycle whenever at most one decoded byte is pending and the output is not
// stalled; the decode of a byte is a single combinational pass from the
// escape state into a three-entry result buffer, which drains one byte per
// cycle unless stalled. A byte that yields two or three results (an unknown
// escape or a broken hex escape) therefore holds the source side until only
// its last result remains; a downstream stall holds it while the stall lasts.
module escape_sequence_decoder (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sym_valid,
	output logic          sym_stall,
	input  esd_pkg::in_t  sym,
	output logic          decoded_valid,
	input  logic          decoded_stall,
	output esd_pkg::out_t decoded
);

	esd_pkg::dec_t res;
	logic          room;
	logic          take;

	assign sym_stall = !room;
	assign take      = sym_valid && room;

	esd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym),
		.take   (take),
		.res    (res)
	);

	esd_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.load          (take),
		.room          (room),
		.decoded_valid (decoded_valid),
		.decoded_stall (decoded_stall),
		.decoded       (decoded)
	);

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		decoded_valid && decoded_stall |-> sym_stall)
		else $error("source accepted while a stalled result is pending");

	a_done_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		decoded_valid && decoded.string_done |-> decoded.run_last)
		else $error("string end marked on a byte that does not close its run");

	a_eos_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && !sym_stall && sym.end_of_string |=> decoded_valid)
		else $error("final byte of a string produced no result");

endmodule
